[rtl/core/hrht_pkg.sv]
`timescale 1ns / 1ps

package hrht_pkg;

   // Widths fixed by the result and configuration formats.
   localparam int POS_W   = 12;
   localparam int HLEN_W  = 13;
   localparam int LIMIT_W = 13;
   localparam int KIND_W  = 3;

   localparam int MAX_HEADER_DEFAULT = 4096;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // Number of result slots one byte can fill.
   localparam int SLOTS = 3;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      PH_REQ  = 2'd0,
      PH_HDR  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      EV_METHOD    = 3'd0,
      EV_URI       = 3'd1,
      EV_PROTOCOL  = 3'd2,
      EV_FIELD     = 3'd3,
      EV_COMPLETE  = 3'd4,
      EV_TOO_LARGE = 3'd5
   } event_type;

   typedef struct packed {
      event_type           kind;
      logic [POS_W-1:0]    name_start;
      logic [POS_W-1:0]    name_len;
      logic [POS_W-1:0]    value_start;
      logic [POS_W-1:0]    value_len;
      logic [HLEN_W-1:0]   header_length;
   } result_type;

   // Expected character at each position of the CR LF CR LF terminator.
   function automatic logic [7:0] term_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0: ch = CH_CR;
         2'd1: ch = CH_LF;
         2'd2: ch = CH_CR;
         2'd3: ch = CH_LF;
         default: ch = CH_CR;
      endcase
      return ch;
   endfunction

endpackage

[rtl/core/http_request_header_tokenizer_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                tdata / tuser
// req_      in         req_tvalid/req_tready    tdata[7:0] data_byte, tuser[0] first
// rsp_      out        rsp_tvalid/rsp_tready    tdata name_start..header_length,
//                                               tuser event_kind, tlast last
// csr_      in         csr_wr_en (no wait)      csr_wr_data[12:0] header_limit
//
// A request is taken into an input register and scanned once the bundle is free; its zero
// to three results land in a result bundle register. A byte with at most one result
// moves at one per cycle while rsp_tready is high; one with three results holds the
// bundle until all three are taken. Reset is synchronous and active high; it clears
// the scan state and sets the header limit to 4096. A stalled result side holds the
// bundle and one more request in the input register before req_tready drops.

module http_request_header_tokenizer_top
   import hrht_pkg::*;
#(
   parameter int MAX_HEADER = MAX_HEADER_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic [0:0]          req_tuser,   // [0] first
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,   // [11:0] name_start, [23:12] name_len,
                                            // [35:24] value_start, [47:36] value_len,
                                            // [60:48] header_length, [63:61] zero
   output logic [KIND_W-1:0]   rsp_tuser,   // [2:0] event_kind
   output logic                rsp_tlast,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   // The byte offset must hold the full buffer size.
   localparam int OFFW = $clog2(MAX_HEADER + 1);
   localparam int CMPW = (OFFW > LIMIT_W) ? OFFW : LIMIT_W;

   // Configuration register.
   logic [LIMIT_W-1:0] header_limit_ff;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   // Scan state.
   phase_type         phase_ff,     phase_in;
   logic [1:0]        tok_idx_ff,   tok_idx_in;
   logic [POS_W-1:0]  run_cnt_ff,   run_cnt_in;
   logic [7:0]        prev_char_ff, prev_char_in;
   logic              value_seen_ff, value_seen_in;
   logic [OFFW-1:0]   byte_ofs_ff,  byte_ofs_in;
   logic [1:0]        end_match_ff, end_match_in;
   logic [POS_W-1:0]  fld_start_ff [SLOTS];
   logic [POS_W-1:0]  fld_start_in [SLOTS];
   logic [POS_W-1:0]  fld_len_ff   [SLOTS];
   logic [POS_W-1:0]  fld_len_in   [SLOTS];

   // Result bundle.
   result_type        slot_ff [SLOTS];
   result_type        slot_in [SLOTS];
   logic [1:0]        out_cnt_ff, out_cnt_in;
   logic [1:0]        out_idx_ff, out_idx_in;
   logic [1:0]        res_cnt;

   logic              rsp_fire;
   logic              bundle_free;
   logic              take_item;
   logic [CMPW-1:0]   limit_eff;

   assign rsp_tvalid  = (out_cnt_ff != 2'd0);
   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign rsp_tlast   = (out_idx_ff == (out_cnt_ff - 2'd1));
   // The bundle can take new results when it is empty or its last result leaves now.
   assign bundle_free = (out_cnt_ff == 2'd0) || (rsp_fire && rsp_tlast);
   assign take_item   = in_valid_ff && bundle_free;
   assign req_tready  = !in_valid_ff || take_item;

   assign rsp_tuser = slot_ff[out_idx_ff].kind;
   assign rsp_tdata = {3'b000,
                       slot_ff[out_idx_ff].header_length,
                       slot_ff[out_idx_ff].value_len,
                       slot_ff[out_idx_ff].value_start,
                       slot_ff[out_idx_ff].name_len,
                       slot_ff[out_idx_ff].name_start};

   // A limit above the buffer size behaves as the buffer size.
   assign limit_eff = (CMPW'(header_limit_ff) > CMPW'(MAX_HEADER)) ?
                      CMPW'(MAX_HEADER) : CMPW'(header_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         header_limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
      end
   end

   // Scan of one byte: line tokenizing, terminator match, limit check.
   always_comb begin
      logic             ends;
      logic             matched;
      logic             active;
      logic [1:0]       ti;
      logic [1:0]       k;
      logic [OFFW-1:0]  pos;
      logic [CMPW-1:0]  count;
      result_type       cand [5];
      logic [4:0]       cand_vld;
      logic [7:0]       c;

      ends     = 1'b0;
      matched  = 1'b0;
      active   = 1'b0;
      ti       = 2'd0;
      k        = 2'd0;
      c        = in_byte_ff;
      cand_vld = '0;
      for (int i = 0; i < 5; i++) begin
         cand[i] = '0;
      end

      phase_in      = phase_ff;
      tok_idx_in    = tok_idx_ff;
      run_cnt_in    = run_cnt_ff;
      prev_char_in  = prev_char_ff;
      value_seen_in = value_seen_ff;
      byte_ofs_in   = byte_ofs_ff;
      end_match_in  = end_match_ff;
      for (int i = 0; i < SLOTS; i++) begin
         fld_start_in[i] = fld_start_ff[i];
         fld_len_in[i]   = fld_len_ff[i];
      end

      if (take_item && in_first_ff) begin
         phase_in      = PH_REQ;
         byte_ofs_in   = '0;
         end_match_in  = 2'd0;
         tok_idx_in    = 2'd0;
         run_cnt_in    = '0;
         prev_char_in  = 8'h00;
         value_seen_in = 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            fld_start_in[i] = '0;
            fld_len_in[i]   = '0;
         end
      end

      active = take_item && ((phase_in == PH_REQ) || (phase_in == PH_HDR));
      pos    = byte_ofs_in;
      count  = CMPW'(pos) + CMPW'(1);

      if (active) begin
         if (phase_in == PH_REQ) begin
            ti = (tok_idx_in > 2'd2) ? 2'd2 : tok_idx_in;
            case (c)
               CH_SPACE: begin
                  if (prev_char_in != CH_SPACE) begin
                     fld_len_in[ti] = run_cnt_in;
                     run_cnt_in     = '0;
                  end
               end
               CH_CR: begin
                  fld_len_in[ti] = run_cnt_in;
                  run_cnt_in     = '0;
               end
               CH_LF: begin
                  ends = (prev_char_in == CH_CR);
               end
               default: begin
                  if (prev_char_in == CH_SPACE) begin
                     // A fourth token closes the request line.
                     if (ti == 2'd2) begin
                        ends = 1'b1;
                     end else begin
                        ti               = ti + 2'd1;
                        fld_start_in[ti] = POS_W'(pos);
                        run_cnt_in       = POS_W'(1);
                     end
                  end else begin
                     run_cnt_in = run_cnt_in + POS_W'(1);
                  end
               end
            endcase
            tok_idx_in = ti;
            if (ends) begin
               cand[0] = '{kind: EV_METHOD, name_start: '0, name_len: '0,
                           value_start: fld_start_in[0], value_len: fld_len_in[0],
                           header_length: '0};
               cand[1] = '{kind: EV_URI, name_start: '0, name_len: '0,
                           value_start: fld_start_in[1], value_len: fld_len_in[1],
                           header_length: '0};
               cand[2] = '{kind: EV_PROTOCOL, name_start: '0, name_len: '0,
                           value_start: fld_start_in[2], value_len: fld_len_in[2],
                           header_length: '0};
               cand_vld[0] = (fld_len_in[0] != '0);
               cand_vld[1] = (fld_len_in[1] != '0);
               cand_vld[2] = (fld_len_in[2] != '0);
               phase_in    = PH_HDR;
            end
         end else begin
            case (c)
               CH_SPACE: begin
                  if ((prev_char_in != CH_COLON) && (tok_idx_in != 2'd0)) begin
                     run_cnt_in = run_cnt_in + POS_W'(1);
                  end
               end
               CH_COLON: begin
                  if (tok_idx_in == 2'd0) begin
                     fld_len_in[0] = run_cnt_in;
                     run_cnt_in    = '0;
                     tok_idx_in    = 2'd1;
                  end else begin
                     run_cnt_in = run_cnt_in + POS_W'(1);
                  end
               end
               CH_CR: begin
                  if (tok_idx_in != 2'd0) begin
                     fld_len_in[1] = run_cnt_in;
                  end
               end
               CH_LF: begin
                  ends = (prev_char_in == CH_CR);
               end
               default: begin
                  // The value opens only on a non-space byte after a space.
                  if (!value_seen_in && (tok_idx_in != 2'd0) &&
                      (prev_char_in == CH_SPACE)) begin
                     fld_start_in[1] = POS_W'(pos);
                     value_seen_in   = 1'b1;
                     run_cnt_in      = POS_W'(1);
                  end else begin
                     run_cnt_in = run_cnt_in + POS_W'(1);
                  end
               end
            endcase
            if (ends) begin
               cand[3] = '{kind: EV_FIELD, name_start: fld_start_in[0],
                           name_len: fld_len_in[0], value_start: fld_start_in[1],
                           value_len: fld_len_in[1], header_length: '0};
               cand_vld[3] = (fld_len_in[0] != '0) && value_seen_in &&
                             (fld_len_in[1] != '0);
            end
         end

         if (ends) begin
            // Start of the next line.
            tok_idx_in    = 2'd0;
            run_cnt_in    = '0;
            prev_char_in  = 8'h00;
            value_seen_in = 1'b0;
            fld_start_in[0] = POS_W'(count);
            fld_start_in[1] = '0;
            fld_start_in[2] = '0;
            fld_len_in[0]   = '0;
            fld_len_in[1]   = '0;
            fld_len_in[2]   = '0;
         end else begin
            prev_char_in = c;
         end

         byte_ofs_in = OFFW'(count);

         k = end_match_in;
         if (c == term_char(k)) begin
            if (k == 2'd3) begin
               matched = 1'b1;
            end else begin
               k = k + 2'd1;
            end
         end else begin
            k = (c == CH_CR) ? 2'd1 : 2'd0;
         end
         end_match_in = k;

         if (matched && (count < limit_eff)) begin
            cand[4] = '{kind: EV_COMPLETE, name_start: '0, name_len: '0,
                        value_start: '0, value_len: '0,
                        header_length: HLEN_W'(count)};
            cand_vld[4] = 1'b1;
            phase_in    = PH_DONE;
         end else if (count >= limit_eff) begin
            phase_in = PH_DONE;
         end
      end

      // Pack the candidates into the bundle in order.
      res_cnt = 2'd0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_in[i] = '0;
      end
      for (int i = 0; i < 5; i++) begin
         if (cand_vld[i] && (res_cnt != 2'd3)) begin
            slot_in[res_cnt] = cand[i];
            res_cnt          = res_cnt + 2'd1;
         end
      end
      // Reaching the limit replaces every other result of this byte.
      if (active && !(matched && (count < limit_eff)) && (count >= limit_eff)) begin
         slot_in[0] = '{kind: EV_TOO_LARGE, name_start: '0, name_len: '0,
                        value_start: '0, value_len: '0, header_length: '0};
         res_cnt    = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_REQ;
         tok_idx_ff    <= 2'd0;
         run_cnt_ff    <= '0;
         prev_char_ff  <= 8'h00;
         value_seen_ff <= 1'b0;
         byte_ofs_ff   <= '0;
         end_match_ff  <= 2'd0;
         for (int i = 0; i < SLOTS; i++) begin
            fld_start_ff[i] <= '0;
            fld_len_ff[i]   <= '0;
         end
      end else begin
         phase_ff      <= phase_in;
         tok_idx_ff    <= tok_idx_in;
         run_cnt_ff    <= run_cnt_in;
         prev_char_ff  <= prev_char_in;
         value_seen_ff <= value_seen_in;
         byte_ofs_ff   <= byte_ofs_in;
         end_match_ff  <= end_match_in;
         for (int i = 0; i < SLOTS; i++) begin
            fld_start_ff[i] <= fld_start_in[i];
            fld_len_ff[i]   <= fld_len_in[i];
         end
      end
   end

   // Bundle count and read index.
   always_comb begin
      out_cnt_in = out_cnt_ff;
      out_idx_in = out_idx_ff;
      if (take_item) begin
         out_cnt_in = res_cnt;
         out_idx_in = 2'd0;
      end else if (rsp_fire) begin
         if (rsp_tlast) begin
            out_cnt_in = 2'd0;
            out_idx_in = 2'd0;
         end else begin
            out_idx_in = out_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
         out_idx_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_item) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   // The read index never passes the number of results held.
   assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff != 2'd0) |-> (out_idx_ff < out_cnt_ff))
      else $error("result index beyond bundle count");

   // Too-large is always the only result of its byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == EV_TOO_LARGE)) |-> (rsp_tlast && (out_idx_ff == 2'd0)))
      else $error("too-large result shares its byte with other results");

   // A completion or too-large result leaves the scanner finished.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == EV_COMPLETE) || (rsp_tuser == EV_TOO_LARGE)))
      |-> (phase_ff == PH_DONE))
      else $error("scan not finished after final result");

   // The byte offset never exceeds the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      (CMPW'(byte_ofs_ff) <= CMPW'(MAX_HEADER)))
      else $error("byte offset beyond buffer size");
`endif

endmodule
